// ----- hdl/murmur_hash_partitioner_top_macros.svh -----
// Assertion macros used by the partitioner checker.
`ifndef MURMUR_HASH_PARTITIONER_TOP_MACROS_SVH
`define MURMUR_HASH_PARTITIONER_TOP_MACROS_SVH

// Clocked property, ignored while reset is held.
`define MHP_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property, also checked across reset.
`define MHP_ASSERT_ANY(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/mhp_pkg.sv -----
// Package: widths, register indexes, hash constants and state type of the partitioner.
`timescale 1ns / 1ps
`default_nettype none

package mhp_pkg;

  localparam int KEY_W                  = 64;
  localparam int HASH_W                 = 32;
  localparam int CNT_W                  = 11;
  localparam int IDX_OUT_W              = 10;
  localparam int TALLY_W                = 32;
  localparam int CFG_IDX_W              = 2;
  localparam int CFG_DATA_W             = 11;
  localparam int DEFAULT_MAX_PARTITIONS = 1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_PART_COUNT = 2'd0,
    REG_WIDE_KEY   = 2'd1,
    REG_FINAL_PASS = 2'd2
  } cfg_reg_t;

  localparam logic [HASH_W-1:0] MIX_C1     = 32'hcc9e2d51;
  localparam logic [HASH_W-1:0] MIX_C2     = 32'h1b873593;
  localparam logic [HASH_W-1:0] MIX_ADD    = 32'he6546b64;
  localparam logic [HASH_W-1:0] FMIX_M1    = 32'h85ebca6b;
  localparam logic [HASH_W-1:0] FMIX_M2    = 32'hc2b2ae35;
  localparam logic [HASH_W-1:0] LEN_NARROW = 32'd4;
  localparam logic [HASH_W-1:0] LEN_WIDE   = 32'd8;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_MUL1,
    ST_MUL2,
    ST_MIX,
    ST_FMIX1,
    ST_FMIX2,
    ST_FMIX3,
    ST_DIV,
    ST_RD,
    ST_WR,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// ----- hdl/murmur_hash_partitioner_top.sv -----
// Top level: MurmurHash3 x86_32 key hasher with partition assignment and per-partition counters.
`timescale 1ns / 1ps
`default_nettype none

// Hash partitioner. Each accepted word carries a 4- or 8-byte key, a null flag and the row's
// running hash; the result word gives murmur3_32(key, seed 0) + 31 * running hash (the running
// hash unchanged for a null key). In the final pass the hash is reduced modulo the partition
// count and that partition's 32-bit counter (held in a single-port RAM of MAX_PARTITIONS words)
// is incremented; the new count is returned. Items are handled one at a time: hashing runs on
// one shared 32x32 multiplier, then the result is presented and the next word is taken. The
// final pass adds a one-bit-per-cycle remainder unit, then a read and a write-back of the
// counter RAM. After reset the counter RAM is cleared one word per cycle, during which
// in_stall stays high; configuration writes are taken throughout. A finished result waits in
// the output register while the next word is accepted.
module murmur_hash_partitioner_top #(
  parameter int MAX_PARTITIONS = mhp_pkg::DEFAULT_MAX_PARTITIONS
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          cfg_we,
  input  wire logic [mhp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [mhp_pkg::CFG_DATA_W-1:0] cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [mhp_pkg::KEY_W-1:0]     in_key_bits,
  input  wire logic                          in_key_present,
  input  wire logic [mhp_pkg::HASH_W-1:0]    in_running_hash,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [mhp_pkg::HASH_W-1:0]         out_new_hash,
  output logic [mhp_pkg::IDX_OUT_W-1:0]      out_partition_index,
  output logic [mhp_pkg::TALLY_W-1:0]        out_partition_tally
);

  import mhp_pkg::*;

  localparam int IDX_W  = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
  localparam int CLAMP  = (MAX_PARTITIONS > 2047) ? 2047 : MAX_PARTITIONS;
  localparam int STEP_W = $clog2(HASH_W);
  localparam logic [CNT_W-1:0]  CLAMP_CNT = CNT_W'(CLAMP);
  localparam logic [IDX_W-1:0]  LAST_ADDR = IDX_W'(MAX_PARTITIONS - 1);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(HASH_W - 1);

  // Control state
  state_t              state_r, state_nxt;
  logic [CNT_W-1:0]    part_count_r;
  logic                wide_key_r;
  logic                final_pass_r;
  logic [IDX_W-1:0]    clr_addr_r;
  logic                out_valid_r;

  // Datapath
  logic [KEY_W-1:0]    key_r;
  logic                present_r;
  logic [HASH_W-1:0]   running_r;
  logic [HASH_W-1:0]   run31_r;
  logic                hi_blk_r;
  logic [HASH_W-1:0]   k_r;
  logic [HASH_W-1:0]   h_r;
  logic [HASH_W-1:0]   div_num_r;
  logic [CNT_W-1:0]    rem_r;
  logic [CNT_W-1:0]    divisor_r;
  logic [STEP_W-1:0]   div_cnt_r;
  logic [TALLY_W-1:0]  rd_data_r;
  logic [TALLY_W-1:0]  tally_r;
  logic [HASH_W-1:0]   out_hash_r;
  logic [IDX_OUT_W-1:0] out_idx_r;
  logic [TALLY_W-1:0]  out_tally_r;

  logic [TALLY_W-1:0]  cnt_mem [MAX_PARTITIONS];

  logic                in_accept;
  logic                out_load;
  logic                mem_we;
  logic [IDX_W-1:0]    mem_addr;
  logic [TALLY_W-1:0]  mem_wdata;
  logic [IDX_W-1:0]    idx;
  logic [CNT_W-1:0]    eff_count;

  logic [HASH_W-1:0]   mul_a, mul_b, mul_p;
  logic [HASH_W-1:0]   fm1_t;
  logic [HASH_W-1:0]   mix_x, mix_rot, h_mix;
  logic [HASH_W-1:0]   fm3, hash_fin;
  logic [CNT_W:0]      rem_sh;
  logic [CNT_W:0]      rem_diff;

  assign in_accept = in_valid && !in_stall;
  assign idx       = IDX_W'(rem_r);

  // Zero means one partition; clamp to the RAM depth.
  always_comb begin
    if (part_count_r == '0) begin
      eff_count = CNT_W'(1);
    end else if (32'(part_count_r) > MAX_PARTITIONS) begin
      eff_count = CLAMP_CNT;
    end else begin
      eff_count = part_count_r;
    end
  end

  // Shared multiplier, low word only
  always_comb begin
    fm1_t = h_r ^ (wide_key_r ? LEN_WIDE : LEN_NARROW);
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_MUL1: begin
        mul_a = hi_blk_r ? key_r[KEY_W-1:HASH_W] : key_r[HASH_W-1:0];
        mul_b = MIX_C1;
      end
      ST_MUL2: begin
        mul_a = {k_r[16:0], k_r[31:17]};
        mul_b = MIX_C2;
      end
      ST_FMIX1: begin
        mul_a = fm1_t ^ (fm1_t >> 16);
        mul_b = FMIX_M1;
      end
      ST_FMIX2: begin
        mul_a = h_r ^ (h_r >> 13);
        mul_b = FMIX_M2;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_comb begin
    mix_x    = h_r ^ k_r;
    mix_rot  = {mix_x[18:0], mix_x[31:19]};
    h_mix    = (mix_rot << 2) + mix_rot + MIX_ADD;
    fm3      = h_r ^ (h_r >> 16);
    hash_fin = present_r ? (fm3 + run31_r) : running_r;
    rem_sh   = {rem_r, div_num_r[HASH_W-1]};
    rem_diff = rem_sh - {1'b0, divisor_r};
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: if (clr_addr_r == LAST_ADDR) state_nxt = ST_IDLE;
      ST_IDLE:  if (in_valid) state_nxt = ST_MUL1;
      ST_MUL1:  state_nxt = ST_MUL2;
      ST_MUL2:  state_nxt = ST_MIX;
      ST_MIX:   state_nxt = (wide_key_r && !hi_blk_r) ? ST_MUL1 : ST_FMIX1;
      ST_FMIX1: state_nxt = ST_FMIX2;
      ST_FMIX2: state_nxt = ST_FMIX3;
      ST_FMIX3: state_nxt = final_pass_r ? ST_DIV : ST_DONE;
      ST_DIV:   if (div_cnt_r == LAST_STEP) state_nxt = ST_RD;
      ST_RD:    state_nxt = ST_WR;
      ST_WR:    state_nxt = ST_DONE;
      ST_DONE:  if (!out_valid_r || !out_stall) state_nxt = ST_IDLE;
      default:  state_nxt = ST_CLEAR;
    endcase
  end

  // State outputs
  always_comb begin
    in_stall  = 1'b1;
    out_load  = 1'b0;
    mem_we    = 1'b0;
    mem_addr  = idx;
    mem_wdata = rd_data_r + 1'b1;
    unique case (state_r)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_addr  = clr_addr_r;
        mem_wdata = '0;
      end
      ST_IDLE: in_stall = 1'b0;
      ST_WR:   mem_we = 1'b1;
      ST_DONE: out_load = !out_valid_r || !out_stall;
      default: begin
        in_stall = 1'b1;
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      part_count_r <= CNT_W'(1);
      wide_key_r   <= 1'b0;
      final_pass_r <= 1'b0;
      clr_addr_r   <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == ST_CLEAR) begin
        clr_addr_r <= clr_addr_r + 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_we) begin
        unique case (cfg_index)
          REG_PART_COUNT: part_count_r <= cfg_data;
          REG_WIDE_KEY:   wide_key_r   <= cfg_data[0];
          REG_FINAL_PASS: final_pass_r <= cfg_data[0];
          default: ;
        endcase
      end
    end
  end

  // Hash, remainder and result registers
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          key_r     <= in_key_bits;
          present_r <= in_key_present;
          running_r <= in_running_hash;
          run31_r   <= (in_running_hash << 5) - in_running_hash;
          hi_blk_r  <= 1'b0;
          h_r       <= '0;
        end
      end
      ST_MUL1, ST_MUL2: k_r <= mul_p;
      ST_MIX: begin
        h_r      <= h_mix;
        hi_blk_r <= 1'b1;
      end
      ST_FMIX1, ST_FMIX2: h_r <= mul_p;
      ST_FMIX3: begin
        h_r       <= hash_fin;
        div_num_r <= hash_fin;
        rem_r     <= '0;
        div_cnt_r <= '0;
        divisor_r <= eff_count;
      end
      ST_DIV: begin
        div_num_r <= div_num_r << 1;
        div_cnt_r <= div_cnt_r + 1'b1;
        if (rem_sh >= {1'b0, divisor_r}) begin
          rem_r <= rem_diff[CNT_W-1:0];
        end else begin
          rem_r <= rem_sh[CNT_W-1:0];
        end
      end
      ST_WR: tally_r <= mem_wdata;
      default: ;
    endcase
    if (out_load) begin
      out_hash_r  <= h_r;
      out_idx_r   <= final_pass_r ? IDX_OUT_W'(rem_r) : '0;
      out_tally_r <= final_pass_r ? tally_r : '0;
    end
  end

  // Partition counter RAM
  always_ff @(posedge clk) begin
    if (mem_we) begin
      cnt_mem[mem_addr] <= mem_wdata;
    end
    if (state_r == ST_RD) begin
      rd_data_r <= cnt_mem[idx];
    end
  end

  assign out_valid           = out_valid_r;
  assign out_new_hash        = out_hash_r;
  assign out_partition_index = out_idx_r;
  assign out_partition_tally = out_tally_r;

endmodule

`default_nettype wire

// ----- hdl/mhp_checker.sv -----
// Port-level checker for the hash partitioner, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

`include "murmur_hash_partitioner_top_macros.svh"

module mhp_checker (
  input wire logic                          clk,
  input wire logic                          rst_n,
  input wire logic                          cfg_we,
  input wire logic [mhp_pkg::CFG_IDX_W-1:0] cfg_index,
  input wire logic [mhp_pkg::CFG_DATA_W-1:0] cfg_data,
  input wire logic                          in_valid,
  input wire logic                          in_stall,
  input wire logic [mhp_pkg::KEY_W-1:0]     in_key_bits,
  input wire logic                          in_key_present,
  input wire logic [mhp_pkg::HASH_W-1:0]    in_running_hash,
  input wire logic                          out_valid,
  input wire logic                          out_stall,
  input wire logic [mhp_pkg::HASH_W-1:0]    out_new_hash,
  input wire logic [mhp_pkg::IDX_OUT_W-1:0] out_partition_index,
  input wire logic [mhp_pkg::TALLY_W-1:0]   out_partition_tally
);

  // Reset starts the counter clear, so no word may be taken just after it.
  `MHP_ASSERT_ANY(a_reset_stalls, !rst_n |=> in_stall, "input taken straight after reset")

  // One word at a time: busy in the cycle after an accept.
  `MHP_ASSERT(a_busy_after_accept, in_valid && !in_stall |=> in_stall, "second word taken while busy")

  // No result can appear in the cycle after a word is taken into an empty block.
  `MHP_ASSERT(a_min_latency, in_valid && !in_stall && !out_valid |=> !out_valid, "result too early")

  // Hold a stalled result.
  `MHP_ASSERT(a_out_hold, out_valid && out_stall |=> out_valid && $stable(out_new_hash) && $stable(out_partition_index) && $stable(out_partition_tally), "stalled result changed")

endmodule

bind murmur_hash_partitioner_top mhp_checker u_mhp_checker (.*);

`default_nettype wire
